### hdl/jog_mpg_feed_mixer_assert.svh
// Assertion macros used by the jog mixer top level.
`ifndef JOG_MPG_FEED_MIXER_ASSERT_SVH
`define JOG_MPG_FEED_MIXER_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define JMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define JMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/jmf_pkg.sv
package jmf_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JOY_DEADBAND,
    CFG_JOY_SPEED_SLOW,
    CFG_JOY_SPEED_FAST,
    CFG_COUNTS_PER_UNIT
  } jmf_cfg_e;

  localparam logic [14:0] JOY_DEADBAND_RST    = 15'd1638;
  localparam logic [15:0] JOY_SPEED_SLOW_RST  = 16'd100;
  localparam logic [15:0] JOY_SPEED_FAST_RST  = 16'd5000;
  localparam logic [23:0] COUNTS_PER_UNIT_RST = 24'd10000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MOVE,
    ST_SCALE,
    ST_FEED,
    ST_DELTA,
    ST_ACCUM,
    ST_DONE
  } jmf_state_e;

  typedef struct packed {
    logic capture;
    logic prep;
    logic move;
    logic scale;
    logic feed;
    logic delta;
    logic accum;
    logic load_out;
  } jmf_cmd_t;

  typedef struct packed {
    logic out_full;
  } jmf_status_t;

endpackage

### hdl/jmf_ctrl.sv
module jmf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  jmf_pkg::jmf_status_t status_i,
  output jmf_pkg::jmf_cmd_t    cmd_o
);
  import jmf_pkg::*;

  jmf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_PREP;
      ST_PREP:  state_d = ST_MOVE;
      ST_MOVE:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_FEED;
      ST_FEED:  state_d = ST_DELTA;
      ST_DELTA: state_d = ST_ACCUM;
      ST_ACCUM: state_d = ST_DONE;
      ST_DONE:  if (!status_i.out_full) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_PREP:  cmd_o.prep  = 1'b1;
      ST_MOVE:  cmd_o.move  = 1'b1;
      ST_SCALE: cmd_o.scale = 1'b1;
      ST_FEED:  cmd_o.feed  = 1'b1;
      ST_DELTA: cmd_o.delta = 1'b1;
      ST_ACCUM: cmd_o.accum = 1'b1;
      ST_DONE:  cmd_o.load_out = !status_i.out_full;
      default:  cmd_o = '0;
    endcase
  end

endmodule

### hdl/jmf_datapath.sv
module jmf_datapath #(
  parameter int unsigned ACC_WIDTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  jmf_pkg::jmf_cmd_t                  cmd_i,
  output jmf_pkg::jmf_status_t               status_o,
  input  logic                               cfg_we_i,
  input  logic [jmf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [jmf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic signed [31:0]                 wheel_count_i,
  input  logic [23:0]                        wheel_scale_i,
  input  logic signed [15:0]                 joy_position_i,
  input  logic                               joy_button_i,
  input  logic                               feed_forward_i,
  input  logic                               feed_reverse_i,
  input  logic signed [31:0]                 spindle_position_i,
  input  logic signed [23:0]                 lead_per_rev_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [31:0]                 position_count_o,
  output logic                               velocity_mode_o,
  output logic                               fast_active_o
);
  import jmf_pkg::*;

  localparam logic signed [65:0] AccHi = (66'sd1 <<< (ACC_WIDTH - 1)) - 66'sd1;
  localparam logic signed [65:0] AccLo = -AccHi - 66'sd1;
  localparam logic signed [63:0] PosHi = 64'sh7fff_ffff;
  localparam logic signed [63:0] PosLo = -64'sh8000_0000;

  // configuration
  logic [14:0] deadband_q;
  logic [15:0] speed_slow_q, speed_fast_q;
  logic [23:0] cpu_q;

  // block state
  logic                        first_q, fast_q, btn_prev_q;
  logic [31:0]                 wheel_ref_q, spindle_ref_q;
  logic signed [ACC_WIDTH-1:0] acc_q, acc_d;
  logic                        out_valid_q;

  // captured item
  logic signed [31:0] wheel_in_q, spindle_in_q;
  logic [23:0]        wscale_in_q;
  logic signed [15:0] joy_in_q;
  logic               button_in_q, fwd_in_q, rev_in_q;
  logic signed [23:0] fpr_in_q;

  // pipeline payload
  logic signed [31:0] wd_q, sd_q, wd_d, sd_d;
  logic signed [16:0] jv_q, jv_d;
  logic               feed_en_q, feed_neg_q, vel_q, fneg_q;
  logic signed [57:0] move_q, move_d;
  logic signed [55:0] fp_q;
  logic [55:0]        pl_q;
  logic [47:0]        ph_q;
  logic [61:0]        r_q;
  logic signed [63:0] delta_q, delta_d;
  logic signed [31:0] pos_q;
  logic               vel_out_q, fast_out_q;

  // combinational helpers
  logic [31:0]        wref_eff, sref_eff;
  logic signed [16:0] joy17, db17;
  logic               vel;
  logic [15:0]        speed;
  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] mul_p;
  logic [55:0]        mag;
  logic [79:0]        scaled;
  logic signed [63:0] feed_val;
  logic signed [65:0] acc_sum;
  logic signed [63:0] acc64, q64;
  logic signed [31:0] pos_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q   <= JOY_DEADBAND_RST;
      speed_slow_q <= JOY_SPEED_SLOW_RST;
      speed_fast_q <= JOY_SPEED_FAST_RST;
      cpu_q        <= COUNTS_PER_UNIT_RST;
    end else if (cfg_we_i) begin
      case (jmf_cfg_e'(cfg_idx_i))
        CFG_JOY_DEADBAND:    deadband_q   <= cfg_data_i[14:0];
        CFG_JOY_SPEED_SLOW:  speed_slow_q <= cfg_data_i[15:0];
        CFG_JOY_SPEED_FAST:  speed_fast_q <= cfg_data_i[15:0];
        CFG_COUNTS_PER_UNIT: cpu_q        <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // prep: first-tick reference load, toggle, deadband, differences
  always_comb begin
    wref_eff = first_q ? wheel_in_q : wheel_ref_q;
    sref_eff = first_q ? spindle_in_q : spindle_ref_q;
    wd_d     = wheel_in_q - wref_eff;
    sd_d     = spindle_in_q - sref_eff;
    joy17    = 17'(joy_in_q);
    db17     = signed'({2'b00, deadband_q});
    if (joy17 > -db17 && joy17 < db17) begin
      jv_d = '0;
    end else if (joy17 > 17'sd0) begin
      jv_d = joy17 - db17;
    end else begin
      jv_d = joy17 + db17;
    end
  end

  // move: one shared multiplier for velocity or handwheel, one for feed
  always_comb begin
    vel    = jv_q != '0;
    speed  = fast_q ? speed_fast_q : speed_slow_q;
    mul_a  = vel ? 33'(jv_q) : 33'(wd_q);
    mul_b  = vel ? signed'({9'd0, speed}) : signed'({1'b0, wscale_in_q});
    mul_p  = 58'(mul_a) * 58'(mul_b);
    move_d = vel ? (mul_p <<< 1) : mul_p;
  end

  always_comb begin
    mag      = fp_q[55] ? 56'(-fp_q) : 56'(fp_q);
    scaled   = {ph_q, 32'd0} + {24'd0, pl_q};
    feed_val = fneg_q ? -signed'({2'b00, r_q}) : signed'({2'b00, r_q});
    delta_d  = 64'(move_q) + (feed_en_q ? feed_val : 64'sd0);
    acc_sum  = 66'(acc_q) + 66'(delta_q);
    if (acc_sum > AccHi) begin
      acc_d = ACC_WIDTH'(AccHi);
    end else if (acc_sum < AccLo) begin
      acc_d = ACC_WIDTH'(AccLo);
    end else begin
      acc_d = ACC_WIDTH'(acc_sum);
    end
    acc64 = 64'(acc_q);
    q64   = acc64 >>> 16;
    if (acc64[63] && (acc64[15:0] != 16'd0)) begin
      q64 = q64 + 64'sd1;
    end
    if (q64 > PosHi) begin
      pos_d = 32'(PosHi);
    end else if (q64 < PosLo) begin
      pos_d = 32'(PosLo);
    end else begin
      pos_d = 32'(q64);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q       <= 1'b1;
      fast_q        <= 1'b1;
      btn_prev_q    <= 1'b0;
      wheel_ref_q   <= '0;
      spindle_ref_q <= '0;
      acc_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.prep) begin
        first_q     <= 1'b0;
        fast_q      <= fast_q ^ (button_in_q & ~btn_prev_q);
        btn_prev_q  <= button_in_q;
        wheel_ref_q <= wheel_in_q;
        if (first_q || cpu_q != '0) begin
          spindle_ref_q <= spindle_in_q;
        end
      end
      if (cmd_i.accum) begin
        acc_q <= acc_d;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      wheel_in_q   <= wheel_count_i;
      wscale_in_q  <= wheel_scale_i;
      joy_in_q     <= joy_position_i;
      button_in_q  <= joy_button_i;
      fwd_in_q     <= feed_forward_i;
      rev_in_q     <= feed_reverse_i;
      spindle_in_q <= spindle_position_i;
      fpr_in_q     <= lead_per_rev_i;
    end
    if (cmd_i.prep) begin
      wd_q       <= wd_d;
      sd_q       <= sd_d;
      jv_q       <= jv_d;
      feed_en_q  <= (cpu_q != '0) && (fwd_in_q || rev_in_q);
      feed_neg_q <= !fwd_in_q;
    end
    if (cmd_i.move) begin
      move_q <= move_d;
      vel_q  <= vel;
      fp_q   <= 56'(sd_q) * 56'(fpr_in_q);
    end
    if (cmd_i.scale) begin
      pl_q   <= 56'(mag[31:0]) * 56'(cpu_q);
      ph_q   <= 48'(mag[55:32]) * 48'(cpu_q);
      fneg_q <= fp_q[55] ^ feed_neg_q;
    end
    if (cmd_i.feed) begin
      r_q <= scaled[77:16];
    end
    if (cmd_i.delta) begin
      delta_q <= delta_d;
    end
    if (cmd_i.load_out) begin
      pos_q      <= pos_d;
      vel_out_q  <= vel_q;
      fast_out_q <= fast_q;
    end
  end

  assign status_o.out_full = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign position_count_o  = pos_q;
  assign velocity_mode_o   = vel_out_q;
  assign fast_active_o     = fast_out_q;

endmodule

### hdl/jog_mpg_feed_mixer.sv
// Jog / handwheel / spindle-feed mixer, one servo tick per input transfer.
// Input channel: in_valid_i with in_stall_o; one transfer carries the wheel
// count and scale, joystick and button, feed requests, spindle position and
// feed per rev. Output channel: out_valid_o with out_stall_i; one result per
// tick: saturated position count, velocity mode flag and fast-mode flag.
// Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 deadband,
// 1 slow speed, 2 fast speed, 3 counts per unit); write only while idle.
// The controller walks the datapath steps in order (prep, move, scale, feed,
// delta, accumulate, output) and takes no new tick until the current one
// has loaded its result into the output register.
// The block takes a new tick while the previous result waits in the output
// register; if the receiver stalls, the finished tick holds in the last stage
// and the block accepts nothing more until the output register frees up.
// Reset: registers return to defaults, accumulator clears, fast mode is on,
// and the first tick after reset loads the wheel and spindle references.
module jog_mpg_feed_mixer #(
  parameter int unsigned ACC_WIDTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [jmf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jmf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [31:0]             wheel_count_i,
  input  logic [23:0]                    wheel_scale_i,
  input  logic signed [15:0]             joy_position_i,
  input  logic                           joy_button_i,
  input  logic                           feed_forward_i,
  input  logic                           feed_reverse_i,
  input  logic signed [31:0]             spindle_position_i,
  input  logic signed [23:0]             lead_per_rev_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [31:0]             position_count_o,
  output logic                           velocity_mode_o,
  output logic                           fast_active_o
);
  import jmf_pkg::*;

  jmf_cmd_t    cmd;
  jmf_status_t status;

  jmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  jmf_datapath #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .wheel_count_i      (wheel_count_i),
    .wheel_scale_i      (wheel_scale_i),
    .joy_position_i     (joy_position_i),
    .joy_button_i       (joy_button_i),
    .feed_forward_i     (feed_forward_i),
    .feed_reverse_i     (feed_reverse_i),
    .spindle_position_i (spindle_position_i),
    .lead_per_rev_i     (lead_per_rev_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .position_count_o   (position_count_o),
    .velocity_mode_o    (velocity_mode_o),
    .fast_active_o      (fast_active_o)
  );

`include "jog_mpg_feed_mixer_assert.svh"

  `JMF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accepted while busy")
  `JMF_ASSERT_NOW(a_single_step, 1'b1, $onehot0(cmd), "more than one datapath step")
  `JMF_ASSERT_NOW(a_load_when_free, cmd.load_out, !(out_valid_o && out_stall_i), "result overwrite")
  `JMF_ASSERT_NEXT(a_out_drain, out_valid_o && !out_stall_i && !cmd.load_out, !out_valid_o, "repeat")

endmodule

### tb/jog_mpg_feed_mixer_checker.sv
module jog_mpg_feed_mixer_checker
  import jmf_pkg::*;
#(
  parameter int unsigned ACC_WIDTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic signed [31:0]      wheel_count_i,
  input  logic [23:0]             wheel_scale_i,
  input  logic signed [15:0]      joy_position_i,
  input  logic                    joy_button_i,
  input  logic                    feed_forward_i,
  input  logic                    feed_reverse_i,
  input  logic signed [31:0]      spindle_position_i,
  input  logic signed [23:0]      lead_per_rev_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [31:0]      position_count_i,
  input  logic                    velocity_mode_i,
  input  logic                    fast_active_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      checked_o
);

  localparam longint POS_MAX = 64'sh7FFF_FFFF;
  localparam longint POS_MIN = -64'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] pos;
    logic               vel;
    logic               fast;
  } mix_result_t;

  mix_result_t expected_q[$];

  logic [14:0] db_r;
  logic [15:0] slow_r;
  logic [15:0] fast_r;
  logic [23:0] cpu_r;

  logic [31:0] wheel_ref;
  logic [31:0] spindle_ref;
  longint      acc;
  logic        fast_sel;
  logic        btn_prev;
  logic        first_tick;

  function automatic mix_result_t mix_tick();
    longint      joy, db, jv, move, feed, wd, sd, prod, mag, mul, sum, hi, lo, q;
    logic [31:0] diff;
    mix_result_t res;
    if (first_tick) begin
      wheel_ref   = wheel_count_i;
      spindle_ref = spindle_position_i;
      acc         = 0;
      first_tick  = 1'b0;
    end
    if (joy_button_i && !btn_prev) fast_sel = !fast_sel;
    btn_prev = joy_button_i;

    joy = joy_position_i;
    db  = db_r;
    if (joy > -db && joy < db) jv = 0;
    else if (joy > 0) jv = joy - db;
    else jv = joy + db;

    if (jv != 0) begin
      mul     = fast_sel ? fast_r : slow_r;
      move    = jv * mul * 2;
      res.vel = 1'b1;
    end else begin
      diff    = wheel_count_i - wheel_ref;
      wd      = $signed(diff);
      mul     = wheel_scale_i;
      move    = wd * mul;
      res.vel = 1'b0;
    end
    wheel_ref = wheel_count_i;

    // zero counts per unit: no feed, spindle reference frozen
    feed = 0;
    if (cpu_r != 0) begin
      diff        = spindle_position_i - spindle_ref;
      sd          = $signed(diff);
      spindle_ref = spindle_position_i;
      if (feed_forward_i || feed_reverse_i) begin
        prod = sd * lead_per_rev_i;
        mag  = (prod < 0) ? -prod : prod;
        mul  = cpu_r;
        feed = (mag / 65536) * mul + ((mag % 65536) * mul) / 65536;
        if (prod < 0) feed = -feed;
        if (!feed_forward_i) feed = -feed;
      end
    end

    sum = move + feed;
    hi  = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
    lo  = -hi - 1;
    if (sum > 0 && acc > hi - sum) acc = hi;
    else if (sum < 0 && acc < lo - sum) acc = lo;
    else acc = acc + sum;

    q = acc / 65536;
    if (q > POS_MAX) q = POS_MAX;
    if (q < POS_MIN) q = POS_MIN;
    res.pos  = q[31:0];
    res.fast = fast_sel;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mix_result_t want;
    if (!rst_ni) begin
      db_r         = JOY_DEADBAND_RST;
      slow_r       = JOY_SPEED_SLOW_RST;
      fast_r       = JOY_SPEED_FAST_RST;
      cpu_r        = COUNTS_PER_UNIT_RST;
      wheel_ref    = '0;
      spindle_ref  = '0;
      acc          = 0;
      fast_sel     = 1'b1;
      btn_prev     = 1'b0;
      first_tick   = 1'b1;
      expected_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_JOY_DEADBAND:    db_r   = cfg_data_i[14:0];
          CFG_JOY_SPEED_SLOW:  slow_r = cfg_data_i[15:0];
          CFG_JOY_SPEED_FAST:  fast_r = cfg_data_i[15:0];
          CFG_COUNTS_PER_UNIT: cpu_r  = cfg_data_i[23:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transfer, position_count %0d", $time,
                   position_count_i);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          if (position_count_i !== want.pos) begin
            $display("%0t: position_count expected %0d, got %0d", $time, want.pos,
                     position_count_i);
            fail_count_o++;
          end
          if (velocity_mode_i !== want.vel) begin
            $display("%0t: velocity_mode expected %0b, got %0b", $time, want.vel,
                     velocity_mode_i);
            fail_count_o++;
          end
          if (fast_active_i !== want.fast) begin
            $display("%0t: fast_active expected %0b, got %0b", $time, want.fast,
                     fast_active_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(mix_tick());
      pending_o <= expected_q.size();
    end
  end

endmodule

### tb/tb_jog_mpg_feed_mixer.sv
module tb_jog_mpg_feed_mixer;
  import jmf_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_idx;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [31:0]      wheel_count;
  logic [23:0]             wheel_scale;
  logic signed [15:0]      joy_position;
  logic                    joy_button;
  logic                    feed_forward;
  logic                    feed_reverse;
  logic signed [31:0]      spindle_position;
  logic signed [23:0]      lead_per_rev;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [31:0]      position_count;
  logic                    velocity_mode;
  logic                    fast_active;

  int fail_count;
  int pending;
  int n_checked;

  logic [31:0] wheel_now;
  logic [31:0] spindle_now;
  bit          button_now;
  logic [14:0] cur_db;
  int          n_ticks;
  int          n_settings;
  bit          hold_req;

  jog_mpg_feed_mixer u_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .wheel_count_i      (wheel_count),
    .wheel_scale_i      (wheel_scale),
    .joy_position_i     (joy_position),
    .joy_button_i       (joy_button),
    .feed_forward_i     (feed_forward),
    .feed_reverse_i     (feed_reverse),
    .spindle_position_i (spindle_position),
    .lead_per_rev_i     (lead_per_rev),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .position_count_o   (position_count),
    .velocity_mode_o    (velocity_mode),
    .fast_active_o      (fast_active)
  );

  jog_mpg_feed_mixer_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .wheel_count_i      (wheel_count),
    .wheel_scale_i      (wheel_scale),
    .joy_position_i     (joy_position),
    .joy_button_i       (joy_button),
    .feed_forward_i     (feed_forward),
    .feed_reverse_i     (feed_reverse),
    .spindle_position_i (spindle_position),
    .lead_per_rev_i     (lead_per_rev),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .position_count_i   (position_count),
    .velocity_mode_i    (velocity_mode),
    .fast_active_i      (fast_active),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .checked_o          (n_checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic push_tick(input logic [31:0] wc, input logic [23:0] ws,
                           input logic [15:0] jp, input bit b, input bit f,
                           input bit r, input logic [31:0] sp, input logic [23:0] fr);
    wheel_count      <= wc;
    wheel_scale      <= ws;
    joy_position     <= jp;
    joy_button       <= b;
    feed_forward     <= f;
    feed_reverse     <= r;
    spindle_position <= sp;
    lead_per_rev     <= fr;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    wheel_now   = wc;
    spindle_now = sp;
    button_now  = b;
    n_ticks++;
  endtask

  task automatic pause(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_regs(input logic [23:0] db, input logic [23:0] slow,
                          input logic [23:0] fast, input logic [23:0] cpu);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_JOY_DEADBAND;
    cfg_data <= db;
    @(posedge clk);
    cfg_idx  <= CFG_JOY_SPEED_SLOW;
    cfg_data <= slow;
    @(posedge clk);
    cfg_idx  <= CFG_JOY_SPEED_FAST;
    cfg_data <= fast;
    @(posedge clk);
    cfg_idx  <= CFG_COUNTS_PER_UNIT;
    cfg_data <= cpu;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_db = db[14:0];
    n_settings++;
  endtask

  // mostly plausible servo ticks: small wheel and spindle steps, some noise
  task automatic rand_tick();
    logic [31:0] wc, sp;
    logic [23:0] ws, fr;
    logic [15:0] jp;
    bit          b, f, r;
    int          k;
    k = $urandom_range(0, 99);
    if (k < 8) begin
      wc = $urandom;
      ws = 24'($urandom);
      jp = 16'($urandom);
      b  = 1'($urandom);
      f  = 1'($urandom);
      r  = 1'($urandom);
      sp = $urandom;
      fr = 24'($urandom);
    end else begin
      wc = (k < 12) ? $urandom : wheel_now + $urandom_range(0, 200) - 100;
      case ($urandom_range(0, 2))
        0:       ws = 24'h010000;
        1:       ws = 24'($urandom_range(0, 24'h0FFFFF));
        default: ws = 24'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: jp = 16'($urandom_range(0, 2000)) - 16'd1000;
        6:                jp = {1'b0, cur_db} + 16'($urandom_range(0, 1));
        7:                jp = -{1'b0, cur_db} - 16'($urandom_range(0, 1));
        default:          jp = 16'($urandom);
      endcase
      b = ($urandom_range(0, 4) == 0) ? !button_now : button_now;
      {f, r} = 2'($urandom_range(0, 3));
      sp = (k < 15) ? $urandom : spindle_now + $urandom_range(0, 32'h40000) - 32'h20000;
      fr = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                       : 24'($urandom_range(0, 32'h20000)) - 24'h010000;
    end
    push_tick(wc, ws, jp, b, f, r, sp, fr);
  endtask

  task automatic run_random(input int n, input bit hold, input bit pause_mid);
    int sent, burst, gap;
    sent = 0;
    while (sent < n) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      for (int i = 0; i < burst && sent < n; i++) begin
        rand_tick();
        sent++;
        if (sent == n / 2) begin
          if (hold) hold_req = 1'b1;
          if (pause_mid) drain();
        end
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) pause(gap);
    end
  endtask

  initial begin : receiver
    int hold_left, mode, cyc;
    hold_left = 0;
    mode      = 0;
    cyc       = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (cyc % 5 < 3);
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("jog_mpg_feed_mixer regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] s0, w0;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_JOY_DEADBAND;
    cfg_data         <= '0;
    in_valid         <= 1'b0;
    wheel_count      <= '0;
    wheel_scale      <= '0;
    joy_position     <= '0;
    joy_button       <= 1'b0;
    feed_forward     <= 1'b0;
    feed_reverse     <= 1'b0;
    spindle_position <= '0;
    lead_per_rev     <= '0;
    wheel_now   = '0;
    spindle_now = '0;
    button_now  = 1'b0;
    cur_db      = JOY_DEADBAND_RST;
    n_ticks     = 0;
    n_settings  = 1;
    hold_req    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: reference load, deadband edges, button edges, wheel wrap, feed modes
    push_tick(32'h1234_5678, 24'h010000, 16'sd0, 1'b0, 1'b0, 1'b0, 32'h4000_0000, 24'h010000);
    push_tick(32'h1234_5682, 24'h010000, 16'sd0, 1'b0, 1'b0, 1'b0, 32'h4000_0000, 24'h010000);
    push_tick(32'h1234_567D, 24'hFFFFFF, 16'sd1637, 1'b0, 1'b0, 1'b0, 32'h4000_0000,
              24'h010000);
    push_tick(32'h1234_5680, 24'h010000, 16'sd1638, 1'b0, 1'b0, 1'b0, 32'h4000_0000,
              24'h010000);
    push_tick(32'h1234_5680, 24'h010000, 16'sd1639, 1'b0, 1'b0, 1'b0, 32'h4000_0000,
              24'h010000);
    push_tick(32'h1234_5680, 24'h010000, 16'h7FFF, 1'b0, 1'b0, 1'b0, 32'h4000_0000, 24'h010000);
    push_tick(32'h1234_5680, 24'h010000, 16'h8000, 1'b0, 1'b0, 1'b0, 32'h4000_0000, 24'h010000);
    push_tick(32'h1234_5680, 24'h010000, 16'h7FFF, 1'b1, 1'b0, 1'b0, 32'h4000_0000, 24'h010000);
    push_tick(32'h7FFF_FFF0, 24'h010000, 16'sd0, 1'b0, 1'b0, 1'b0, 32'h4000_0000, 24'h010000);
    push_tick(32'h8000_0010, 24'h010000, 16'sd0, 1'b0, 1'b0, 1'b0, 32'h4000_0000, 24'h010000);
    push_tick(32'h8000_0010, 24'h010000, 16'sd0, 1'b1, 1'b1, 1'b0, 32'h4001_8000, 24'h010000);
    push_tick(32'h8000_0010, 24'h010000, 16'sd0, 1'b0, 1'b0, 1'b1, 32'h4002_8000, 24'h800000);
    push_tick(32'h8000_0010, 24'h010000, 16'sd0, 1'b0, 1'b1, 1'b1, 32'h4001_8000, 24'h7FFFFF);
    push_tick(32'h8000_0010, 24'h010000, 16'sd0, 1'b0, 1'b0, 1'b0, 32'h4004_8000, 24'h010000);
    run_random(160, 1'b0, 1'b0);

    // zero deadband, full feed: drive the accumulator into both rails
    drain();
    set_regs(24'd0, 24'd0, 24'h00FFFF, 24'hFFFFFF);
    s0 = spindle_now;
    w0 = wheel_now;
    for (int i = 0; i < 8; i++)
      push_tick(w0, 24'h010000, 16'sd0, 1'b0, i < 3, i >= 3,
                (i % 2 == 0) ? s0 ^ 32'h8000_0000 : s0, 24'h800000);
    push_tick(w0 ^ 32'h8000_0000, 24'hFFFFFF, 16'sd0, 1'b0, 1'b0, 1'b0, s0, 24'h010000);
    run_random(160, 1'b0, 1'b0);

    // widest deadband, feed disabled, upper data bits ignored
    drain();
    set_regs(24'hFFFFFF, 24'hFFFFFF, 24'hAB0000, 24'd0);
    push_tick(wheel_now, 24'h010000, 16'h8000, 1'b0, 1'b1, 1'b0, spindle_now + 32'h10000,
              24'h010000);
    push_tick(wheel_now + 3, 24'h010000, 16'h7FFF, 1'b0, 1'b0, 1'b1, spindle_now + 32'h20000,
              24'h010000);
    run_random(160, 1'b1, 1'b0);

    for (int p = 0; p < 3; p++) begin
      drain();
      set_regs(24'($urandom), 24'($urandom), 24'($urandom),
               ($urandom_range(0, 3) == 0) ? 24'd0 :
               ($urandom_range(0, 1) == 0) ? 24'($urandom) : 24'($urandom_range(1, 20000)));
      run_random(160, 1'b0, p == 0);
    end

    drain();
    set_regs(24'd1, 24'd1, 24'd1, 24'd1);
    run_random(160, 1'b0, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d servo ticks under %0d register settings, %0d results compared;",
             n_ticks, n_settings, n_checked);
    $display("covered deadband edges, speed toggles, wheel wrap, feed modes and saturation.");
    if (fail_count == 0 && pending == 0) begin
      $display("jog_mpg_feed_mixer regression: pass");
    end else begin
      $display("jog_mpg_feed_mixer regression: fail");
    end
    $finish;
  end

endmodule

### jog_mpg_feed_mixer.f
+incdir+hdl
hdl/jmf_pkg.sv
hdl/jmf_ctrl.sv
hdl/jmf_datapath.sv
hdl/jog_mpg_feed_mixer.sv
tb/jog_mpg_feed_mixer_checker.sv
tb/tb_jog_mpg_feed_mixer.sv
